[src/aps_pkg.sv]
`default_nettype none

package aps_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned FREQ_W    = 12;

  // long period covers 2000, 1000, 500, 400 and 250; tone period is 300
  localparam int unsigned PER_LONG = 2000;
  localparam int unsigned PER_TONE = 300;
  localparam int unsigned PER_1000 = 1000;
  localparam int unsigned PER_500  = 500;
  localparam int unsigned PER_400  = 400;
  localparam int unsigned PER_250  = 250;

  localparam int unsigned RL_W = 11;
  localparam int unsigned RT_W = 9;

  localparam int unsigned LONG_SHIFT = 27;
  localparam int unsigned LONG_RECIP = (1 << LONG_SHIFT) / PER_LONG + 1;
  localparam int unsigned QL_W       = 6;
  localparam int unsigned TONE_SHIFT = 26;
  localparam int unsigned TONE_RECIP = (1 << TONE_SHIFT) / PER_TONE + 1;
  localparam int unsigned QT_W       = 8;

  // residue correction when the elapsed counter wraps past 2^32
  localparam longint unsigned WRAP_MOD = 64'd4294967296;
  localparam int unsigned WRAP_ADJ_LONG =
    (PER_LONG - int'(WRAP_MOD % longint'(PER_LONG))) % PER_LONG;
  localparam int unsigned WRAP_ADJ_TONE =
    (PER_TONE - int'(WRAP_MOD % longint'(PER_TONE))) % PER_TONE;

  localparam logic [FREQ_W-1:0] TONE_1000  = 12'd1000;
  localparam logic [FREQ_W-1:0] TONE_2000  = 12'd2000;
  localparam logic [FREQ_W-1:0] TONE_2400  = 12'd2400;
  localparam logic [FREQ_W-1:0] TONE_2800  = 12'd2800;
  localparam logic [FREQ_W-1:0] TONE_3200  = 12'd3200;

  localparam logic [1:0] MODE_FAULT     = 2'd1;
  localparam logic [1:0] MODE_ESTOP     = 2'd2;
  localparam logic [1:0] MODE_LINK_LOST = 2'd3;

  localparam logic [1:0] LEVEL_EARLY  = 2'd1;
  localparam logic [1:0] LEVEL_DROWSY = 2'd2;
  localparam logic [1:0] LEVEL_DANGER = 2'd3;

  typedef enum logic [2:0] {
    COND_FAULT       = 3'd0,
    COND_LINK_LOST   = 3'd1,
    COND_SENSOR_LOST = 3'd2,
    COND_L3          = 3'd3,
    COND_L2          = 3'd4,
    COND_L1          = 3'd5,
    COND_L0          = 3'd6
  } cond_e;

  typedef struct packed {
    logic              valid;
    cond_e             cond;
    logic [TICK_W-1:0] tick;
    logic [RL_W-1:0]   tm_long;
    logic [RT_W-1:0]   tm_tone;
  } tick_red_t;

  typedef struct packed {
    logic                 valid;
    cond_e                cond;
    logic [ELAPSED_W-1:0] elapsed;
    logic [RL_W-1:0]      r_long;
    logic [RT_W-1:0]      r_tone;
  } timer_st_t;

  function automatic cond_e derive_cond(logic [1:0] mode, logic [1:0] level,
                                        logic sens, logic link, logic estop);
    cond_e c;
    priority if (mode == MODE_FAULT || mode == MODE_ESTOP || estop) begin
      c = COND_FAULT;
    end else if (link || mode == MODE_LINK_LOST) begin
      c = COND_LINK_LOST;
    end else if (sens) begin
      c = COND_SENSOR_LOST;
    end else begin
      unique case (level)
        LEVEL_DANGER: c = COND_L3;
        LEVEL_DROWSY: c = COND_L2;
        LEVEL_EARLY:  c = COND_L1;
        default:      c = COND_L0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/aps_if.sv]
`default_nettype none

interface aps_tick_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_ms;
  logic [1:0]        vehicle_mode;
  logic [1:0]        alert_level;
  logic              sensor_lost;
  logic              link_lost;
  logic              estop_flag;

  modport source (output valid, tick_ms, vehicle_mode, alert_level, sensor_lost,
                  link_lost, estop_flag, input ready);
  modport sink (input valid, tick_ms, vehicle_mode, alert_level, sensor_lost,
                link_lost, estop_flag, output ready);
endinterface

interface aps_result_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        condition;
  logic              buzzer_on;
  logic [FREQ_W-1:0] buzzer_freq_hz;
  logic              led_red;
  logic              led_green;
  logic              led_blue;

  modport source (output valid, condition, buzzer_on, buzzer_freq_hz, led_red,
                  led_green, led_blue, input ready);
  modport sink (input valid, condition, buzzer_on, buzzer_freq_hz, led_red,
                led_green, led_blue, output ready);
endinterface

`default_nettype wire

[src/aps_reduce.sv]
`default_nettype none

module aps_reduce import aps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic [TICK_W-1:0] tick_ms_i,
  input  wire logic [1:0]        vehicle_mode_i,
  input  wire logic [1:0]        alert_level_i,
  input  wire logic              sensor_lost_i,
  input  wire logic              link_lost_i,
  input  wire logic              estop_flag_i,
  output tick_red_t              red_o
);

  logic              v1_q, v2_q, v3_q;
  logic [TICK_W-1:0] tick1_q, tick2_q, tick3_q;
  cond_e             cond1_q, cond2_q, cond3_q;
  logic [QL_W-1:0]   ql2_q;
  logic [QT_W-1:0]   qt2_q;
  logic [RL_W-1:0]   tml3_q;
  logic [RT_W-1:0]   tmt3_q;

  logic [TICK_W+QL_W+11-1:0] prod_long;
  logic [TICK_W+QT_W+10-1:0] prod_tone;
  logic [QL_W-1:0]           ql_d;
  logic [QT_W-1:0]           qt_d;
  logic [TICK_W-1:0]         ql_back, qt_back;
  logic [RL_W-1:0]           tml_d;
  logic [RT_W-1:0]           tmt_d;

  // quotient by reciprocal, exact over the whole tick range
  assign prod_long = (TICK_W+QL_W+11)'(tick1_q) * (TICK_W+QL_W+11)'(LONG_RECIP);
  assign prod_tone = (TICK_W+QT_W+10)'(tick1_q) * (TICK_W+QT_W+10)'(TONE_RECIP);
  assign ql_d      = QL_W'(prod_long >> LONG_SHIFT);
  assign qt_d      = QT_W'(prod_tone >> TONE_SHIFT);

  assign ql_back = TICK_W'(TICK_W'(ql2_q) * TICK_W'(PER_LONG));
  assign qt_back = TICK_W'(TICK_W'(qt2_q) * TICK_W'(PER_TONE));
  assign tml_d   = RL_W'(tick2_q - ql_back);
  assign tmt_d   = RT_W'(tick2_q - qt_back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tick1_q <= tick_ms_i;
      cond1_q <= derive_cond(vehicle_mode_i, alert_level_i, sensor_lost_i,
                             link_lost_i, estop_flag_i);
      tick2_q <= tick1_q;
      cond2_q <= cond1_q;
      ql2_q   <= ql_d;
      qt2_q   <= qt_d;
      tick3_q <= tick2_q;
      cond3_q <= cond2_q;
      tml3_q  <= tml_d;
      tmt3_q  <= tmt_d;
    end
  end

  assign red_o = '{valid: v3_q, cond: cond3_q, tick: tick3_q,
                   tm_long: tml3_q, tm_tone: tmt3_q};

endmodule

`default_nettype wire

[src/aps_timer.sv]
`default_nettype none

module aps_timer import aps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire tick_red_t red_i,
  output timer_st_t      st_o
);

  localparam int unsigned SL_W = RL_W + 2;
  localparam int unsigned ST_W = RT_W + 2;

  logic                 v_q;
  cond_e                cond_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [RL_W-1:0]      rl_q;
  logic [RT_W-1:0]      rt_q;

  logic [ELAPSED_W:0]   sum;
  logic                 carry;
  logic [SL_W-1:0]      sl;
  logic [ST_W-1:0]      st;
  logic [RL_W-1:0]      rl_add;
  logic [RT_W-1:0]      rt_add;
  logic [ELAPSED_W-1:0] elapsed_d;
  logic [RL_W-1:0]      rl_d;
  logic [RT_W-1:0]      rt_d;

  assign sum   = (ELAPSED_W+1)'(elapsed_q) + (ELAPSED_W+1)'(red_i.tick);
  assign carry = sum[ELAPSED_W];

  always_comb begin
    sl = SL_W'(rl_q) + SL_W'(red_i.tm_long) + (carry ? SL_W'(WRAP_ADJ_LONG) : '0);
    st = ST_W'(rt_q) + ST_W'(red_i.tm_tone) + (carry ? ST_W'(WRAP_ADJ_TONE) : '0);
    priority if (sl >= SL_W'(2 * PER_LONG)) begin
      rl_add = RL_W'(sl - SL_W'(2 * PER_LONG));
    end else if (sl >= SL_W'(PER_LONG)) begin
      rl_add = RL_W'(sl - SL_W'(PER_LONG));
    end else begin
      rl_add = RL_W'(sl);
    end
    priority if (st >= ST_W'(2 * PER_TONE)) begin
      rt_add = RT_W'(st - ST_W'(2 * PER_TONE));
    end else if (st >= ST_W'(PER_TONE)) begin
      rt_add = RT_W'(st - ST_W'(PER_TONE));
    end else begin
      rt_add = RT_W'(st);
    end
    if (red_i.cond != cond_q) begin
      elapsed_d = '0;
      rl_d      = '0;
      rt_d      = '0;
    end else begin
      elapsed_d = sum[ELAPSED_W-1:0];
      rl_d      = rl_add;
      rt_d      = rt_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= 1'b0;
      cond_q    <= COND_L0;
      elapsed_q <= '0;
      rl_q      <= '0;
      rt_q      <= '0;
    end else if (adv_i) begin
      v_q <= red_i.valid;
      if (red_i.valid) begin
        cond_q    <= red_i.cond;
        elapsed_q <= elapsed_d;
        rl_q      <= rl_d;
        rt_q      <= rt_d;
      end
    end
  end

  assign st_o = '{valid: v_q, cond: cond_q, elapsed: elapsed_q,
                  r_long: rl_q, r_tone: rt_q};

endmodule

`default_nettype wire

[src/aps_pattern.sv]
`default_nettype none

module aps_pattern import aps_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire timer_st_t          st_i,
  output logic                    valid_o,
  output logic [2:0]              condition_o,
  output logic                    buzzer_on_o,
  output logic [FREQ_W-1:0]       buzzer_freq_hz_o,
  output logic                    led_red_o,
  output logic                    led_green_o,
  output logic                    led_blue_o
);

  logic              valid_q;
  logic [2:0]        cond_q;
  logic              on_q, red_q, green_q, blue_q;
  logic [FREQ_W-1:0] tone_q;

  logic [RL_W-1:0]   r1000, r500, r250;
  logic              half400;
  logic              on_d, red_d, green_d, blue_d;
  logic [FREQ_W-1:0] tone_d;

  always_comb begin
    r1000 = (st_i.r_long >= RL_W'(PER_1000)) ? RL_W'(st_i.r_long - RL_W'(PER_1000))
                                            : st_i.r_long;
    r500  = (r1000 >= RL_W'(PER_500)) ? RL_W'(r1000 - RL_W'(PER_500)) : r1000;
    r250  = (r500 >= RL_W'(PER_250)) ? RL_W'(r500 - RL_W'(PER_250)) : r500;
    half400 = 1'b0;
    for (int k = 0; k < PER_LONG / PER_400; k++) begin
      if (st_i.r_long >= RL_W'(k * PER_400) &&
          st_i.r_long < RL_W'(k * PER_400 + PER_400 / 2)) begin
        half400 = 1'b1;
      end
    end
  end

  always_comb begin
    on_d    = 1'b0;
    tone_d  = tone_q;
    red_d   = 1'b0;
    green_d = 1'b0;
    blue_d  = 1'b0;
    unique case (st_i.cond)
      COND_FAULT: begin
        on_d   = 1'b1;
        tone_d = TONE_1000;
        red_d  = r1000 < RL_W'(PER_1000 / 2);
      end
      COND_LINK_LOST: begin
        if (st_i.r_long < RL_W'(50)) begin
          on_d   = 1'b1;
          tone_d = TONE_1000;
        end
        red_d   = r500 < RL_W'(PER_500 / 2);
        green_d = red_d;
      end
      COND_SENSOR_LOST: begin
        blue_d = r1000 < RL_W'(PER_1000 / 2);
      end
      COND_L3: begin
        on_d   = 1'b1;
        tone_d = (st_i.r_tone < RT_W'(PER_TONE / 2)) ? TONE_3200 : TONE_2400;
        red_d  = r250 < RL_W'(PER_250 / 2);
      end
      COND_L2: begin
        if (half400) begin
          on_d   = 1'b1;
          tone_d = TONE_2800;
        end
        red_d = 1'b1;
      end
      COND_L1: begin
        // two pulses only, within the first second
        if (st_i.elapsed < ELAPSED_W'(2 * PER_500) && r500 < RL_W'(100)) begin
          on_d   = 1'b1;
          tone_d = TONE_2000;
        end
        red_d   = 1'b1;
        green_d = 1'b1;
      end
      default: begin
        green_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tone_q  <= TONE_2000;
    end else if (adv_i) begin
      valid_q <= st_i.valid;
      if (st_i.valid) begin
        tone_q <= tone_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && st_i.valid) begin
      cond_q  <= st_i.cond;
      on_q    <= on_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o          = valid_q;
  assign condition_o      = cond_q;
  assign buzzer_on_o      = on_q;
  assign buzzer_freq_hz_o = tone_q;
  assign led_red_o        = red_q;
  assign led_green_o      = green_q;
  assign led_blue_o       = blue_q;

endmodule

`default_nettype wire

[src/alert_pattern_sequencer_top.sv]
// Alert pattern sequencer. Takes one tick item per cycle unless a result waits
// to be taken, and presents one result item per tick. Input, quotient and
// remainder stages reduce the tick time modulo 2000 and 300 by reciprocal
// multiplication, one stage updates the condition, the 32-bit elapsed counter
// and its residues, and the last stage derives buzzer and LED states into the
// result register. The whole pipeline holds while a result waits to be taken;
// the tone is held while the buzzer is off and resets to 2000 Hz.
`default_nettype none

module alert_pattern_sequencer_top import aps_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  aps_tick_if.sink     tick_i,
  aps_result_if.source result_o
);

  logic      adv;
  logic      res_valid;
  tick_red_t red;
  timer_st_t st;

  assign adv          = !res_valid || result_o.ready;
  assign tick_i.ready = adv;

  aps_reduce u_reduce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (tick_i.valid),
    .tick_ms_i      (tick_i.tick_ms),
    .vehicle_mode_i (tick_i.vehicle_mode),
    .alert_level_i  (tick_i.alert_level),
    .sensor_lost_i  (tick_i.sensor_lost),
    .link_lost_i    (tick_i.link_lost),
    .estop_flag_i   (tick_i.estop_flag),
    .red_o          (red)
  );

  aps_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .red_i  (red),
    .st_o   (st)
  );

  aps_pattern u_pattern (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .st_i             (st),
    .valid_o          (res_valid),
    .condition_o      (result_o.condition),
    .buzzer_on_o      (result_o.buzzer_on),
    .buzzer_freq_hz_o (result_o.buzzer_freq_hz),
    .led_red_o        (result_o.led_red),
    .led_green_o      (result_o.led_green),
    .led_blue_o       (result_o.led_blue)
  );

  assign result_o.valid = res_valid;

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.r_long < RL_W'(PER_LONG) && st.r_tone < RT_W'(PER_TONE))
    else $error("elapsed residue out of range");

  a_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.cond != $past(st.cond) |-> st.elapsed == '0 && st.r_long == '0 && st.r_tone == '0)
    else $error("condition change did not clear elapsed time");

  a_tone_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.buzzer_freq_hz == TONE_1000 || result_o.buzzer_freq_hz == TONE_2000 ||
    result_o.buzzer_freq_hz == TONE_2400 || result_o.buzzer_freq_hz == TONE_2800 ||
    result_o.buzzer_freq_hz == TONE_3200)
    else $error("buzzer tone outside the fixed set");

endmodule

`default_nettype wire

[test/alert_pattern_sequencer_top_tb.sv]
`timescale 1ns / 100ps

module alert_pattern_sequencer_top_tb;
  import aps_pkg::*;

  localparam logic [1:0] MODE_OTHER   = 2'd0;
  localparam logic [1:0] LEVEL_NORMAL = 2'd0;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [1:0]        mode;
    logic [1:0]        level;
    logic              sens;
    logic              link;
    logic              estop;
  } tick_item_t;

  typedef struct packed {
    cond_e             cond;
    logic              buzzer;
    logic [FREQ_W-1:0] freq;
    logic              red;
    logic              green;
    logic              blue;
  } alert_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  aps_tick_if   tick_bus ();
  aps_result_if res_bus ();

  alert_pattern_sequencer_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .tick_i  (tick_bus),
    .result_o(res_bus)
  );

  always #6 clk = ~clk;

  tick_item_t pending_ticks[$];
  alert_t     alerts_due[$];
  tick_item_t cur_tick;
  int         outstanding = 0;
  int         mismatches  = 0;
  int         tx_gap      = 0;
  int         tx_calm     = 0;
  int         rx_gap      = 0;
  int         rx_calm     = 0;
  int         hold_cnt    = 0;
  bit         hold_req    = 1'b0;

  // predictor state
  cond_e             last_cond = COND_L0;
  logic [31:0]       elapsed   = '0;
  logic [FREQ_W-1:0] tone      = TONE_2000;
  logic              buzzing   = 1'b0;

  function automatic alert_t predict_alert(tick_item_t it);
    cond_e       c;
    alert_t      a;
    logic [31:0] e;
    if (it.mode == MODE_FAULT || it.mode == MODE_ESTOP || it.estop) begin
      c = COND_FAULT;
    end else if (it.link || it.mode == MODE_LINK_LOST) begin
      c = COND_LINK_LOST;
    end else if (it.sens) begin
      c = COND_SENSOR_LOST;
    end else begin
      case (it.level)
        LEVEL_DANGER: c = COND_L3;
        LEVEL_DROWSY: c = COND_L2;
        LEVEL_EARLY:  c = COND_L1;
        default:      c = COND_L0;
      endcase
    end
    if (c != last_cond) begin
      elapsed   = '0;
      last_cond = c;
    end else begin
      elapsed = elapsed + it.tick_ms;
    end
    e = elapsed;
    a = '0;
    a.cond = c;
    buzzing = 1'b0;
    case (c)
      COND_FAULT: begin
        tone    = TONE_1000;
        buzzing = 1'b1;
        a.red   = (e % PER_1000) < (PER_1000 / 2);
      end
      COND_LINK_LOST: begin
        if ((e % PER_LONG) < 50) begin
          tone    = TONE_1000;
          buzzing = 1'b1;
        end
        a.red   = (e % PER_500) < (PER_500 / 2);
        a.green = a.red;
      end
      COND_SENSOR_LOST: begin
        a.blue = (e % PER_1000) < (PER_1000 / 2);
      end
      COND_L3: begin
        tone    = ((e % PER_TONE) < (PER_TONE / 2)) ? TONE_3200 : TONE_2400;
        buzzing = 1'b1;
        a.red   = (e % PER_250) < (PER_250 / 2);
      end
      COND_L2: begin
        if ((e % PER_400) < (PER_400 / 2)) begin
          tone    = TONE_2800;
          buzzing = 1'b1;
        end
        a.red = 1'b1;
      end
      COND_L1: begin
        // two pulses only, at the start of the first two half-second slots
        if ((e / PER_500) < 2 && (e % PER_500) < 100) begin
          tone    = TONE_2000;
          buzzing = 1'b1;
        end
        a.red   = 1'b1;
        a.green = 1'b1;
      end
      default: begin
        a.green = 1'b1;
      end
    endcase
    a.buzzer = buzzing;
    a.freq   = tone;
    return a;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TICK_W-1:0] pick_tick_ms();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 16'($urandom_range(0, 300));
    if (r < 17) return 16'($urandom_range(0, 2000));
    if (r < 19) return 16'($urandom_range(0, 65535));
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  // random fields, then, unless noise is set, forced so that the item lands on the wanted condition
  function automatic tick_item_t shape_tick(cond_e c, logic [TICK_W-1:0] t, bit noise);
    logic [$bits(tick_item_t)-1:0] raw;
    tick_item_t                    it;
    raw = $bits(tick_item_t)'($urandom);
    it = raw;
    it.tick_ms = t;
    if (!noise) begin
      case (c)
        COND_FAULT: begin
          case ($urandom_range(0, 2))
            0:       it.mode  = MODE_FAULT;
            1:       it.mode  = MODE_ESTOP;
            default: it.estop = 1'b1;
          endcase
        end
        COND_LINK_LOST: begin
          it.estop = 1'b0;
          it.mode  = $urandom_range(0, 1) ? MODE_LINK_LOST : MODE_OTHER;
          if (it.mode == MODE_OTHER) it.link = 1'b1;
        end
        COND_SENSOR_LOST: begin
          it.estop = 1'b0;
          it.mode  = MODE_OTHER;
          it.link  = 1'b0;
          it.sens  = 1'b1;
        end
        default: begin
          it.estop = 1'b0;
          it.mode  = MODE_OTHER;
          it.link  = 1'b0;
          it.sens  = 1'b0;
          case (c)
            COND_L3: it.level = LEVEL_DANGER;
            COND_L2: it.level = LEVEL_DROWSY;
            COND_L1: it.level = LEVEL_EARLY;
            default: it.level = LEVEL_NORMAL;
          endcase
        end
      endcase
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_bus.valid <= 1'b0;
    end else if (!tick_bus.valid || tick_bus.ready) begin
      if (tick_bus.valid) alerts_due.push_back(predict_alert(cur_tick));
      if (tx_gap > 0) begin
        tx_gap--;
        tick_bus.valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        cur_tick = pending_ticks.pop_front();
        outstanding++;
        tick_bus.tick_ms      <= cur_tick.tick_ms;
        tick_bus.vehicle_mode <= cur_tick.mode;
        tick_bus.alert_level  <= cur_tick.level;
        tick_bus.sensor_lost  <= cur_tick.sens;
        tick_bus.link_lost    <= cur_tick.link;
        tick_bus.estop_flag   <= cur_tick.estop;
        tick_bus.valid        <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        tick_bus.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alert_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (alerts_due.size() == 0) begin
          $error("result item with no tick waiting for it");
          mismatches++;
        end else begin
          want = alerts_due.pop_front();
          outstanding--;
          check_field("condition", 16'(want.cond), 16'(res_bus.condition));
          check_field("buzzer_on", 16'(want.buzzer), 16'(res_bus.buzzer_on));
          check_field("buzzer_freq_hz", 16'(want.freq), 16'(res_bus.buzzer_freq_hz));
          check_field("led_red", 16'(want.red), 16'(res_bus.led_red));
          check_field("led_green", 16'(want.green), 16'(res_bus.led_green));
          check_field("led_blue", 16'(want.blue), 16'(res_bus.led_blue));
        end
        rx_gap = pick_gap(rx_calm);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 250;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_tick(tick_item_t it);
    while (pending_ticks.size() >= 8) @(posedge clk);
    pending_ticks.push_back(it);
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || outstanding != 0) @(posedge clk);
  endtask

  // runs of one condition so that the elapsed counter walks through the patterns
  task automatic run_random(int count, int hold_at);
    int    n;
    int    run;
    cond_e c;
    n = 0;
    while (n < count) begin
      c   = cond_e'($urandom_range(0, 6));
      run = $urandom_range(1, 30);
      for (int k = 0; k < run && n < count; k++) begin
        push_tick(shape_tick(c, pick_tick_ms(), $urandom_range(0, 9) == 0));
        n++;
        if (n == hold_at) hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    tick_bus.valid        = 1'b0;
    tick_bus.tick_ms      = '0;
    tick_bus.vehicle_mode = MODE_OTHER;
    tick_bus.alert_level  = LEVEL_NORMAL;
    tick_bus.sensor_lost  = 1'b0;
    tick_bus.link_lost    = 1'b0;
    tick_bus.estop_flag   = 1'b0;
    res_bus.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first tick after reset stays in the normal level and adds its time
    push_tick('{16'd5, MODE_OTHER, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    push_tick('{16'hFFFF, MODE_OTHER, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd0, MODE_FAULT, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd600, MODE_ESTOP, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    push_tick('{16'hFFFF, MODE_LINK_LOST, LEVEL_DANGER, 1'b1, 1'b1, 1'b1});
    push_tick('{16'd10, MODE_LINK_LOST, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd60, MODE_OTHER, LEVEL_NORMAL, 1'b0, 1'b1, 1'b0});
    push_tick('{16'd0, MODE_OTHER, LEVEL_DANGER, 1'b1, 1'b0, 1'b0});
    push_tick('{16'd700, MODE_OTHER, LEVEL_NORMAL, 1'b1, 1'b0, 1'b0});
    push_tick('{16'd1, MODE_OTHER, LEVEL_DANGER, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd160, MODE_OTHER, LEVEL_DANGER, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd0, MODE_OTHER, LEVEL_DROWSY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd250, MODE_OTHER, LEVEL_DROWSY, 1'b0, 1'b0, 1'b0});
    // tone held while the buzzer is off
    push_tick('{16'd0, MODE_OTHER, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    // early level: two pulses and then silence
    push_tick('{16'd7, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd99, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd1, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd400, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd99, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd401, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd500, MODE_OTHER, LEVEL_EARLY, 1'b0, 1'b0, 1'b0});
    push_tick('{16'd0, MODE_OTHER, LEVEL_NORMAL, 1'b0, 1'b0, 1'b0});
    drain();

    run_random(420, 150);
    drain();
    run_random(430, -1);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("alert_pattern_sequencer_top_tb OK");
    end else begin
      $display("alert_pattern_sequencer_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("alert_pattern_sequencer_top_tb NOT OK");
    $finish;
  end

endmodule
